>>> design/sfh64_pkg.sv
package sfh64_pkg;

  localparam int unsigned HashW = 64;
  localparam int unsigned LenW  = 10;
  localparam int unsigned PendW = 24;

  localparam logic [LenW-1:0] KEY_LENGTH_RESET = 10'd8;

  // one key's state handed to the finalize pipeline
  typedef struct packed {
    logic [HashW-1:0] hash;
    logic [PendW-1:0] pend;
    logic [1:0]       rem;
    logic             mismatch;
  } fin_t;

  function automatic logic [HashW-1:0] sext8(input logic [7:0] b);
    return {{(HashW-8){b[7]}}, b};
  endfunction

  // mix one complete 4-byte group into the accumulator
  function automatic logic [HashW-1:0] group_mix(input logic [HashW-1:0] h,
                                                 input logic [PendW-1:0] p,
                                                 input logic [7:0]       b);
    logic [HashW-1:0] hh;
    logic [HashW-1:0] hi;
    logic [HashW-1:0] t;
    hh = h + {{(HashW-16){1'b0}}, p[15:0]};
    hi = {{(HashW-16){1'b0}}, b, p[23:16]};
    t  = (hi << 11) ^ hh;
    hh = (hh << 16) ^ t;
    hh = hh + (hh >> 11);
    return hh;
  endfunction

  // fold in 1 to 3 leftover bytes
  function automatic logic [HashW-1:0] tail_mix(input logic [HashW-1:0] h,
                                                input logic [PendW-1:0] p,
                                                input logic [1:0]       rem);
    logic [HashW-1:0] addend;
    logic [HashW-1:0] h1;
    logic [HashW-1:0] h2;
    addend = (rem == 2'd1) ? sext8(p[7:0]) : {{(HashW-16){1'b0}}, p[15:0]};
    h1 = h + addend;
    case (rem)
      2'd3: begin
        h1 = h1 ^ (h1 << 16);
        h1 = h1 ^ (sext8(p[23:16]) << 18);
        h2 = h1 + (h1 >> 11);
      end
      2'd2: begin
        h1 = h1 ^ (h1 << 11);
        h2 = h1 + (h1 >> 17);
      end
      2'd1: begin
        h1 = h1 ^ (h1 << 10);
        h2 = h1 + (h1 >> 1);
      end
      default: h2 = h;
    endcase
    return h2;
  endfunction

  function automatic logic [HashW-1:0] aval_lo(input logic [HashW-1:0] h);
    logic [HashW-1:0] hh;
    hh = h ^ (h << 3);
    hh = hh + (hh >> 5);
    hh = hh ^ (hh << 4);
    return hh;
  endfunction

  function automatic logic [HashW-1:0] aval_hi(input logic [HashW-1:0] h);
    logic [HashW-1:0] hh;
    hh = h + (h >> 17);
    hh = hh ^ (hh << 25);
    hh = hh + (hh >> 6);
    return hh;
  endfunction

endpackage

>>> design/sfh64_final.sv
module sfh64_final (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fin_valid,
  output logic                           fin_ready,
  input  sfh64_pkg::fin_t                fin_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sfh64_pkg::HashW-1:0]    out_hash_value,
  output logic                           out_length_mismatch
);

  logic                        v1_r, v2_r, v3_r, vo_r;
  logic                        v1_nxt, v2_nxt, v3_nxt, vo_nxt;
  sfh64_pkg::fin_t             s1_r;
  logic [sfh64_pkg::HashW-1:0] h2_r, h3_r, ho_r;
  logic                        m2_r, m3_r, mo_r;
  logic                        en1, en2, en3, eno;

  // each stage moves when the one after it is empty or moving
  assign eno = !vo_r || out_ready;
  assign en3 = !v3_r || eno;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign fin_ready = en1;

  always_comb begin
    v1_nxt = en1 ? fin_valid : v1_r;
    v2_nxt = en2 ? v1_r : v2_r;
    v3_nxt = en3 ? v2_r : v3_r;
    vo_nxt = eno ? v3_r : vo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      vo_r <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r <= fin_data;
    end
    if (en2) begin
      h2_r <= sfh64_pkg::tail_mix(s1_r.hash, s1_r.pend, s1_r.rem);
      m2_r <= s1_r.mismatch;
    end
    if (en3) begin
      h3_r <= sfh64_pkg::aval_lo(h2_r);
      m3_r <= m2_r;
    end
    if (eno) begin
      ho_r <= sfh64_pkg::aval_hi(h3_r);
      mo_r <= m3_r;
    end
  end

  assign out_valid           = vo_r;
  assign out_hash_value      = ho_r;
  assign out_length_mismatch = mo_r;

  a_fin_enters: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid && fin_ready |=> v1_r)
    else $error("accepted key did not enter the finalize pipeline");

  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !fin_ready |-> v1_r && v2_r && v3_r && vo_r && !out_ready)
    else $error("finalize pipeline stalled with a bubble");

  a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !en3 |=> v3_r && $stable(h3_r) && $stable(m3_r))
    else $error("stalled stage lost its contents");

endmodule

>>> design/superfast_byte_hash_64.sv
// channel  direction  transfer when          payload
// in       input      in_valid & in_ready    in_data_byte[7:0], in_last_byte
// out      output     out_valid & out_ready  out_hash_value[63:0], out_length_mismatch
// cfg      input      cfg_valid & cfg_ready  cfg_key_length[9:0]
//
// a key byte is taken each cycle in_ready is high; the group mix runs in the accept cycle
// out_valid follows the last byte's transfer through a capture register,
// then the tail stage and the two avalanche halves, the last one being the output register
// cfg_ready is always high; reset sets key_length to 8 and clears the key
// in_ready drops only when all finalize stages and the output hold results
module superfast_byte_hash_64 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sfh64_pkg::HashW-1:0] out_hash_value,
  output logic                        out_length_mismatch,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sfh64_pkg::LenW-1:0]  cfg_key_length
);

  logic [sfh64_pkg::LenW-1:0]  key_length_r, key_length_nxt;
  logic [sfh64_pkg::HashW-1:0] running_hash_r, running_hash_nxt;
  logic [sfh64_pkg::PendW-1:0] pending_r, pending_nxt;
  logic [sfh64_pkg::LenW-1:0]  bytes_seen_r, bytes_seen_nxt;
  logic                        in_key_r, in_key_nxt;
  logic                        count_over_r, count_over_nxt;

  logic                        acc;
  logic                        fin_ready;
  logic [sfh64_pkg::HashW-1:0] h_step;
  logic [sfh64_pkg::PendW-1:0] p_step;
  logic [sfh64_pkg::LenW-1:0]  seen_inc;
  logic                        over_step;
  sfh64_pkg::fin_t             fin_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = fin_ready;
  assign acc       = in_valid && in_ready;

  always_comb begin
    case (bytes_seen_r[1:0])
      2'd0:    p_step = {pending_r[23:8], in_data_byte};
      2'd1:    p_step = {pending_r[23:16], in_data_byte, pending_r[7:0]};
      2'd2:    p_step = {in_data_byte, pending_r[15:0]};
      default: p_step = '0;
    endcase
    h_step = (bytes_seen_r[1:0] == 2'd3)
           ? sfh64_pkg::group_mix(running_hash_r, pending_r, in_data_byte)
           : running_hash_r;
    seen_inc  = bytes_seen_r + 1'b1;
    over_step = count_over_r || (bytes_seen_r == '1);

    fin_data.hash     = h_step;
    fin_data.pend     = p_step;
    fin_data.rem      = seen_inc[1:0];
    fin_data.mismatch = over_step || (seen_inc != key_length_r);
  end

  always_comb begin
    key_length_nxt   = cfg_valid ? cfg_key_length : key_length_r;
    running_hash_nxt = (cfg_valid && !in_key_r)
                     ? {{(sfh64_pkg::HashW-sfh64_pkg::LenW){1'b0}}, cfg_key_length}
                     : running_hash_r;
    pending_nxt      = pending_r;
    bytes_seen_nxt   = bytes_seen_r;
    in_key_nxt       = in_key_r;
    count_over_nxt   = count_over_r;
    if (acc) begin
      if (in_last_byte) begin
        // key done: reseed from the length as it will stand next cycle
        running_hash_nxt = {{(sfh64_pkg::HashW-sfh64_pkg::LenW){1'b0}}, key_length_nxt};
        pending_nxt      = '0;
        bytes_seen_nxt   = '0;
        in_key_nxt       = 1'b0;
        count_over_nxt   = 1'b0;
      end else begin
        running_hash_nxt = h_step;
        pending_nxt      = p_step;
        bytes_seen_nxt   = seen_inc;
        in_key_nxt       = 1'b1;
        count_over_nxt   = over_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r   <= sfh64_pkg::KEY_LENGTH_RESET;
      running_hash_r <= {{(sfh64_pkg::HashW-sfh64_pkg::LenW){1'b0}},
                         sfh64_pkg::KEY_LENGTH_RESET};
      pending_r      <= '0;
      bytes_seen_r   <= '0;
      in_key_r       <= 1'b0;
      count_over_r   <= 1'b0;
    end else begin
      key_length_r   <= key_length_nxt;
      running_hash_r <= running_hash_nxt;
      pending_r      <= pending_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
      in_key_r       <= in_key_nxt;
      count_over_r   <= count_over_nxt;
    end
  end

  sfh64_final u_final (
    .clk                 (clk),
    .rst_n               (rst_n),
    .fin_valid           (acc && in_last_byte),
    .fin_ready           (fin_ready),
    .fin_data            (fin_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hash_value      (out_hash_value),
    .out_length_mismatch (out_length_mismatch)
  );

  a_idle_seed: assert property (@(posedge clk) disable iff (!rst_n)
    !in_key_r |-> running_hash_r ==
      {{(sfh64_pkg::HashW-sfh64_pkg::LenW){1'b0}}, key_length_r})
    else $error("idle accumulator does not hold the key length");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_key_r |-> bytes_seen_r == '0 && pending_r == '0 && !count_over_r)
    else $error("idle key state not cleared");

  a_last_ends_key: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last_byte |=> !in_key_r && bytes_seen_r == '0)
    else $error("last byte did not close the key");

endmodule

>>> sim/tb_superfast_byte_hash_64.sv
module tb_superfast_byte_hash_64;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HashW = sfh64_pkg::HashW;
  localparam int unsigned LenW  = sfh64_pkg::LenW;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItemsPerPhase = 100;

  typedef struct {
    logic [HashW-1:0] hash;
    logic             mismatch;
  } digest_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_data_byte;
  logic              in_last_byte;
  logic              out_valid;
  logic              out_ready;
  logic [HashW-1:0]  out_hash_value;
  logic              out_length_mismatch;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [LenW-1:0]   cfg_key_length;

  // mirror of the block's key state
  logic [LenW-1:0]   key_len_q;
  logic [HashW-1:0]  acc_hash;
  logic [23:0]       pend_bytes;
  logic [LenW-1:0]   seen_cnt;
  logic              in_key;
  logic              cnt_over;

  digest_t           digest_q[$];

  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       hold_off_left;
  int unsigned       err_count;
  int unsigned       byte_count;
  int unsigned       key_count;
  int unsigned       cfg_count;
  int unsigned       quiet_cycles;

  superfast_byte_hash_64 DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hash_value      (out_hash_value),
    .out_length_mismatch (out_length_mismatch),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_key_length      (cfg_key_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [HashW-1:0] sign_ext_byte(input logic [7:0] v);
    return {{(HashW-8){v[7]}}, v};
  endfunction

  function automatic void restart_key();
    acc_hash   = {{(HashW-LenW){1'b0}}, key_len_q};
    pend_bytes = '0;
    seen_cnt   = '0;
    in_key     = 1'b0;
    cnt_over   = 1'b0;
  endfunction

  function automatic void load_key_length(input logic [LenW-1:0] v);
    key_len_q = v;
    // the seed follows a write only while no key is open
    if (!in_key) acc_hash = {{(HashW-LenW){1'b0}}, v};
  endfunction

  // fold one accepted byte into the mirror, queue the digest on the last one
  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    logic [HashW-1:0] h;
    logic [HashW-1:0] hi;
    logic [HashW-1:0] t;
    logic [23:0]      p;
    logic [1:0]       pos;
    logic [1:0]       rem;
    digest_t          d;
    h   = acc_hash;
    p   = pend_bytes;
    pos = seen_cnt[1:0];
    if (pos == 2'd3) begin
      h  = h + {{(HashW-16){1'b0}}, p[15:0]};
      hi = {{(HashW-16){1'b0}}, b, p[23:16]};
      t  = (hi << 11) ^ h;
      h  = (h << 16) ^ t;
      h  = h + (h >> 11);
      p  = '0;
    end else begin
      p = p | ({16'd0, b} << (8 * pos));
    end
    if (seen_cnt == {LenW{1'b1}}) cnt_over = 1'b1;
    seen_cnt = seen_cnt + 1'b1;
    if (!last) begin
      acc_hash   = h;
      pend_bytes = p;
      in_key     = 1'b1;
      return;
    end
    rem = seen_cnt[1:0];
    case (rem)
      2'd3: begin
        h = h + {{(HashW-16){1'b0}}, p[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sign_ext_byte(p[23:16]) << 18);
        h = h + (h >> 11);
      end
      2'd2: begin
        h = h + {{(HashW-16){1'b0}}, p[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      2'd1: begin
        h = h + sign_ext_byte(p[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: ;
    endcase
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    d.hash     = h;
    d.mismatch = cnt_over || (seen_cnt != key_len_q);
    digest_q.insert(digest_q.size(), d);
    restart_key();
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = b;
    in_last_byte = last;
    do @(posedge clk); while (!in_ready);
    absorb_byte(b, last);
    byte_count++;
  endtask

  task automatic send_key(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
    end
  endtask

  // drop valid, wait until every pending digest has been checked, then let the pipeline drain
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (digest_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_key_length(input logic [LenW-1:0] v);
    @(negedge clk);
    cfg_valid      = 1'b1;
    cfg_key_length = v;
    do @(posedge clk); while (!cfg_ready);
    load_key_length(v);
    cfg_count++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed();
    logic [7:0] reset_key[8];
    reset_key = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // reset length of 8 with no write
    foreach (reset_key[i]) send_byte(reset_key[i], i == 7);
    settle();
    // lone negative tail byte
    write_key_length(10'd1);
    send_byte(8'h80, 1'b1);
    settle();
    write_key_length(10'd2);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    settle();
    // third tail byte is signed
    write_key_length(10'd3);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h80, 1'b1);
    settle();
    // zero length always flags
    write_key_length(10'd0);
    send_byte(8'h7F, 1'b1);
    settle();
    // tail follows bytes received, not the register
    write_key_length(10'd5);
    for (int i = 0; i < 4; i++) send_byte(8'hFF, i == 3);
    settle();
    write_key_length(10'd1023);
    for (int i = 0; i < 5; i++) send_byte(8'(i), i == 4);
    settle();
  endtask

  task automatic test_seed_timing();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_key_length(10'd6);
    repeat (3) send_byte(8'($urandom), 1'b0);
    settle();
    // new length only moves the expected count, seed stays 6
    write_key_length(10'd7);
    repeat (3) send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
    settle();
  endtask

  task automatic test_long_key();
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    // count wraps back to 1, overflow must still flag
    write_key_length(10'd1);
    send_key(1025);
    settle();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_key_length(10'd1);
    hold_off_left = 300;
    repeat (40) send_byte(8'($urandom), 1'b1);
    settle();
  endtask

  function automatic logic [LenW-1:0] pick_key_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return LenW'($urandom_range(1, 24));
    if (r < 80) return '0;
    if (r < 90) return {LenW{1'b1}};
    return LenW'($urandom);
  endfunction

  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned sent;
    int unsigned len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_key_length(pick_key_length());
    sent = 0;
    while (sent < RandomItemsPerPhase) begin
      if ($urandom_range(99) < 10) begin
        settle();
        write_key_length(pick_key_length());
      end
      // mostly well-formed keys, the rest of random length
      if (key_len_q >= 1 && key_len_q <= 24 && $urandom_range(99) < 75) len = key_len_q;
      else len = $urandom_range(1, 24);
      send_key(len);
      sent += len;
    end
    settle();
  endtask

  // receiver side, stalls at random or for a counted hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready = 1'b0;
        hold_off_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each digest transfer against the oldest prediction
  always @(posedge clk) begin
    digest_t d;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected result: hash_value %h length_mismatch %b",
               out_hash_value, out_length_mismatch);
        err_count++;
      end else begin
        d = digest_q.pop_front();
        key_count++;
        if (out_hash_value !== d.hash) begin
          $error("hash_value mismatch: expected %h, actual %h", d.hash, out_hash_value);
          err_count++;
        end
        if (out_length_mismatch !== d.mismatch) begin
          $error("length_mismatch mismatch: expected %b, actual %b",
                 d.mismatch, out_length_mismatch);
          err_count++;
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_last_byte   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_key_length = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 0;
    err_count      = 0;
    byte_count     = 0;
    key_count      = 0;
    cfg_count      = 0;
    key_len_q      = sfh64_pkg::KEY_LENGTH_RESET;
    restart_key();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_seed_timing();
    test_backpressure();
    test_long_key();
    test_random(0, 0);
    test_random(61, 0);
    test_random(0, 61);
    test_random(28, 28);
    settle();

    $display("covered %0d key bytes, %0d digests checked, %0d key_length writes",
             byte_count, key_count, cfg_count);
    $display("tails of 0 to 3 bytes, zero and full-scale lengths, overflow, stalls");
    if (err_count == 0 && digest_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
